>>> hw/rtl/scale_notification_decoder_assert.svh
// ----------------------------------------------------------------------------
// scale_notification_decoder_assert.svh
// Assertion macros shared by the decoder checker.
// ----------------------------------------------------------------------------
`ifndef SCALE_NOTIFICATION_DECODER_ASSERT_SVH
`define SCALE_NOTIFICATION_DECODER_ASSERT_SVH

// same-cycle implication
`define SND_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SND_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/snd_pkg.sv
// ----------------------------------------------------------------------------
// snd_pkg
// Types and constants for the scale notification decoder.
// ----------------------------------------------------------------------------
package snd_pkg;

    localparam logic [7:0] HDR_FIRST     = 8'hEF;
    localparam logic [7:0] HDR_SECOND    = 8'hDD;
    localparam logic [7:0] TOPIC_BATTERY = 8'h08;
    localparam logic [7:0] TOPIC_WEIGHT  = 8'h0C;
    localparam logic [7:0] TYPE_WEIGHT   = 8'h05;
    localparam logic [6:0] BATTERY_MASK  = 7'h7F;
    localparam int unsigned SIGN_BIT     = 1;

    localparam logic [8:0] OFFSET_MAX     = 9'd261;
    localparam logic [8:0] OFF_START      = 9'd2;
    localparam logic [8:0] OFF_TOPIC      = 9'd2;
    localparam logic [8:0] OFF_LENGTH     = 9'd3;
    localparam logic [8:0] OFF_TYPE       = 9'd4;
    localparam logic [8:0] OFF_WEIGHT_LO  = 9'd5;
    localparam logic [8:0] OFF_WEIGHT_HI  = 9'd6;
    localparam logic [8:0] OFF_UNIT       = 9'd9;
    localparam logic [8:0] OFF_FLAGS      = 9'd10;
    localparam logic [8:0] MIN_FRAME      = 9'd5;
    localparam logic [9:0] FRAME_OVERHEAD = 10'd5;
    localparam logic [7:0] MIN_WEIGHT_LEN = 8'd6;
    localparam logic [7:0] MAX_PLACES     = 8'd4;

    typedef struct packed {
        logic        has_battery;
        logic [6:0]  battery_percent;
        logic        has_weight;
        logic [15:0] weight_raw;
        logic [2:0]  decimal_places;
        logic        weight_negative;
    } t_reading;

endpackage

>>> hw/rtl/scale_notification_decoder.sv
// ----------------------------------------------------------------------------
// scale_notification_decoder
// Byte-stream decoder for scale notifications: battery and weight readings.
// ----------------------------------------------------------------------------
// Takes one buffer byte per cycle while o_stall is low, with no gaps between
// buffers. The first 0xEF 0xDD pair in a buffer starts the frame; topic,
// length, type, weight, unit and flags bytes are captured as they pass. On
// the byte flagged last, one reading is produced and all frame state clears.
// The reading is registered into a two-entry output register (main plus
// skid) holding readings while the output stalls; input stall rises only when
// both entries are full. Weight = (-1)^negative * weight_raw / 10^places.
// ----------------------------------------------------------------------------
module scale_notification_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_has_battery,
    output logic [6:0]  o_battery_percent,
    output logic        o_has_weight,
    output logic [15:0] o_weight_raw,
    output logic [2:0]  o_decimal_places,
    output logic        o_weight_negative
);

    logic        r_prev_first, n_prev_first;
    logic        r_hdr_found,  n_hdr_found;
    logic [8:0]  r_offset,     n_offset;
    logic [7:0]  r_topic,      n_topic;
    logic [7:0]  r_length,     n_length;
    logic [7:0]  r_type,       n_type;
    logic [15:0] r_weight,     n_weight;
    logic [7:0]  r_unit,       n_unit;
    logic [7:0]  r_flags,      n_flags;

    logic                r_out_valid;
    snd_pkg::t_reading   r_out;
    logic                r_skid_valid;
    snd_pkg::t_reading   r_skid;

    logic                in_acc;
    logic                res_valid;
    logic                frame_ok;
    snd_pkg::t_reading   res;

    assign o_stall   = r_skid_valid;
    assign in_acc    = i_valid && !r_skid_valid;
    assign res_valid = in_acc && i_last_byte;

    always_comb begin
        n_prev_first = r_prev_first;
        n_hdr_found  = r_hdr_found;
        n_offset     = r_offset;
        n_topic      = r_topic;
        n_length     = r_length;
        n_type       = r_type;
        n_weight     = r_weight;
        n_unit       = r_unit;
        n_flags      = r_flags;
        if (r_hdr_found) begin
            unique case (r_offset)
                snd_pkg::OFF_TOPIC:     n_topic         = i_data_byte;
                snd_pkg::OFF_LENGTH:    n_length        = i_data_byte;
                snd_pkg::OFF_TYPE:      n_type          = i_data_byte;
                snd_pkg::OFF_WEIGHT_LO: n_weight[7:0]   = i_data_byte;
                snd_pkg::OFF_WEIGHT_HI: n_weight[15:8]  = i_data_byte;
                snd_pkg::OFF_UNIT:      n_unit          = i_data_byte;
                snd_pkg::OFF_FLAGS:     n_flags         = i_data_byte;
                default: ;
            endcase
            if (r_offset < snd_pkg::OFFSET_MAX) begin
                n_offset = r_offset + 9'd1;
            end
        end else if (r_prev_first && (i_data_byte == snd_pkg::HDR_SECOND)) begin
            n_hdr_found  = 1'b1;
            n_offset     = snd_pkg::OFF_START;
            n_prev_first = 1'b0;
        end else begin
            n_prev_first = (i_data_byte == snd_pkg::HDR_FIRST);
        end
    end

    always_comb begin
        res      = '0;
        frame_ok = n_hdr_found && (n_offset >= snd_pkg::MIN_FRAME)
                   && ({1'b0, n_offset} >= ({2'b00, n_length} + snd_pkg::FRAME_OVERHEAD));
        if (frame_ok) begin
            if (n_topic == snd_pkg::TOPIC_BATTERY) begin
                res.has_battery     = 1'b1;
                res.battery_percent = n_type[6:0] & snd_pkg::BATTERY_MASK;
            end
            if ((n_topic == snd_pkg::TOPIC_WEIGHT) && (n_type == snd_pkg::TYPE_WEIGHT)
                && (n_length >= snd_pkg::MIN_WEIGHT_LEN)) begin
                res.has_weight      = 1'b1;
                res.weight_raw      = n_weight;
                res.decimal_places  = ((n_unit != 8'd0) && (n_unit <= snd_pkg::MAX_PLACES))
                                      ? n_unit[2:0] : 3'd0;
                res.weight_negative = n_flags[snd_pkg::SIGN_BIT];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_first <= 1'b0;
            r_hdr_found  <= 1'b0;
            r_offset     <= '0;
            r_topic      <= '0;
            r_length     <= '0;
            r_type       <= '0;
            r_weight     <= '0;
            r_unit       <= '0;
            r_flags      <= '0;
        end else if (in_acc) begin
            if (i_last_byte) begin
                r_prev_first <= 1'b0;
                r_hdr_found  <= 1'b0;
                r_offset     <= '0;
                r_topic      <= '0;
                r_length     <= '0;
                r_type       <= '0;
                r_weight     <= '0;
                r_unit       <= '0;
                r_flags      <= '0;
            end else begin
                r_prev_first <= n_prev_first;
                r_hdr_found  <= n_hdr_found;
                r_offset     <= n_offset;
                r_topic      <= n_topic;
                r_length     <= n_length;
                r_type       <= n_type;
                r_weight     <= n_weight;
                r_unit       <= n_unit;
                r_flags      <= n_flags;
            end
        end
    end

    // two-entry output: main register plus skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= res_valid;
            end else begin
                r_out_valid  <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out  <= r_skid;
                r_skid <= res;
            end else begin
                r_out  <= res;
            end
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_has_battery     = r_out.has_battery;
    assign o_battery_percent = r_out.battery_percent;
    assign o_has_weight      = r_out.has_weight;
    assign o_weight_raw      = r_out.weight_raw;
    assign o_decimal_places  = r_out.decimal_places;
    assign o_weight_negative = r_out.weight_negative;

endmodule

>>> hw/rtl/snd_checker.sv
// ----------------------------------------------------------------------------
// snd_checker
// Port-level checks on the scale notification decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "scale_notification_decoder_assert.svh"

module snd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_has_battery,
    input logic [6:0]  o_battery_percent,
    input logic        o_has_weight,
    input logic [15:0] o_weight_raw,
    input logic [2:0]  o_decimal_places,
    input logic        o_weight_negative
);

    logic [28:0] out_bits;
    logic        weight_clear;

    assign out_bits     = {o_has_battery, o_battery_percent, o_has_weight,
                           o_weight_raw, o_decimal_places, o_weight_negative};
    assign weight_clear = (o_weight_raw == 16'd0) && (o_decimal_places == 3'd0)
                          && !o_weight_negative;

    `SND_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(out_bits), "stalled transaction changed")
    `SND_ASSERT_NOW(a_no_weight_zero, i_clk, i_rst_n, o_valid && !o_has_weight, weight_clear, "weight fields set without weight")
    `SND_ASSERT_NOW(a_no_battery_zero, i_clk, i_rst_n, o_valid && !o_has_battery, o_battery_percent == 7'd0, "battery field set without battery")
    `SND_ASSERT_NOW(a_places_range, i_clk, i_rst_n, o_valid, o_decimal_places <= 3'd4, "decimal places out of range")
    `SND_ASSERT_NEXT(a_stall_drain, i_clk, i_rst_n, o_stall && !i_stall, !o_stall, "input stall held after output drained")

endmodule

bind scale_notification_decoder snd_checker u_snd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_has_battery     (o_has_battery),
    .o_battery_percent (o_battery_percent),
    .o_has_weight      (o_has_weight),
    .o_weight_raw      (o_weight_raw),
    .o_decimal_places  (o_decimal_places),
    .o_weight_negative (o_weight_negative)
);
